/* rtl/core/fqt_pkg.sv */
// Shared types and constants for the FIFO queue with traverse.
// Holds the request kinds, result status codes and controller command types.
// No dependencies.
package fqt_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		KIND_ENQ  = 2'd0,
		KIND_DEQ  = 2'd1,
		KIND_CLR  = 2'd2,
		KIND_TRAV = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ENQ,
		OP_FULL,
		OP_EMPTY,
		OP_CLR,
		OP_DEQ_START,
		OP_DEQ_EMIT,
		OP_TRAV_START,
		OP_TRAV_EMIT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic out_free;
		logic trav_last;
	} dp_stat_t;

endpackage

/* rtl/core/fqt_ctrl.sv */
// Controller state machine for the FIFO queue with traverse.
// Decodes requests and sequences dequeue and traverse; depends on fqt_pkg.
module fqt_ctrl import fqt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  dp_stat_t    stat,
	output dp_cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEQ,
		ST_TRAV
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   take;

	assign in_stall = !((state_q == ST_IDLE) && stat.out_free);
	assign take = in_valid && !in_stall;

	always_comb begin
		cmd.op = OP_NONE;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					unique case (kind_t'(kind))
						KIND_ENQ: begin
							cmd.op = stat.full ? OP_FULL : OP_ENQ;
						end
						KIND_DEQ: begin
							if (stat.empty) begin
								cmd.op = OP_EMPTY;
							end else begin
								cmd.op = OP_DEQ_START;
								state_nx = ST_DEQ;
							end
						end
						KIND_CLR: begin
							cmd.op = OP_CLR;
						end
						KIND_TRAV: begin
							if (stat.empty) begin
								cmd.op = OP_EMPTY;
							end else begin
								cmd.op = OP_TRAV_START;
								state_nx = ST_TRAV;
							end
						end
						default: begin
							cmd.op = OP_NONE;
						end
					endcase
				end
			end
			ST_DEQ: begin
				if (stat.out_free) begin
					cmd.op = OP_DEQ_EMIT;
					state_nx = ST_IDLE;
				end
			end
			ST_TRAV: begin
				if (stat.out_free) begin
					cmd.op = OP_TRAV_EMIT;
					if (stat.trav_last) begin
						state_nx = ST_IDLE;
					end
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
		cmd.load_out = (cmd.op == OP_ENQ) || (cmd.op == OP_FULL) || (cmd.op == OP_EMPTY) ||
			(cmd.op == OP_CLR) || (cmd.op == OP_DEQ_EMIT) || (cmd.op == OP_TRAV_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

/* rtl/core/fqt_datapath.sv */
// Datapath for the FIFO queue with traverse: slot memory, ring pointers,
// front and rear registers and the result register. Depends on fqt_pkg.
module fqt_datapath import fqt_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   cmd,
	output dp_stat_t                  stat,
	input  logic signed [DATA_W-1:0]  value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic signed [DATA_W-1:0]  data,
	output logic [COUNT_W-1:0]        count,
	output logic signed [DATA_W-1:0]  front_item,
	output logic signed [DATA_W-1:0]  rear_item,
	output logic                      last
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [DATA_W-1:0] mem [DEPTH];

	logic [IW-1:0]            head_q;
	logic [IW-1:0]            tail_q;
	logic [IW-1:0]            idx_q;
	logic [CW-1:0]            occ_q;
	logic [CW-1:0]            rem_q;
	logic signed [DATA_W-1:0] front_q;
	logic signed [DATA_W-1:0] rear_q;
	logic signed [DATA_W-1:0] rd_q;

	logic                     out_valid_q;
	logic [1:0]               status_q;
	logic signed [DATA_W-1:0] data_q;
	logic [COUNT_W-1:0]       count_q;
	logic signed [DATA_W-1:0] front_out_q;
	logic signed [DATA_W-1:0] rear_out_q;
	logic                     last_q;

	logic                     rd_en;
	logic [IW-1:0]            rd_addr;
	logic [1:0]               o_status;
	logic signed [DATA_W-1:0] o_data;
	logic [CW-1:0]            o_count;
	logic signed [DATA_W-1:0] o_front;
	logic signed [DATA_W-1:0] o_rear;
	logic                     o_last;

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
		return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	assign stat.empty = (occ_q == '0);
	assign stat.full = (occ_q == CW'(DEPTH));
	assign stat.out_free = !out_valid_q || !out_stall;
	assign stat.trav_last = (rem_q == CW'(1));

	always_comb begin
		rd_en = 1'b0;
		rd_addr = head_q;
		o_status = STATUS_OK;
		o_data = '0;
		o_count = occ_q;
		o_front = '0;
		o_rear = '0;
		o_last = 1'b1;
		unique case (cmd.op)
			OP_ENQ: begin
				o_count = occ_q + 1'b1;
				o_front = (occ_q == '0) ? value : front_q;
				o_rear = value;
			end
			OP_FULL: begin
				o_status = STATUS_FULL;
				o_front = front_q;
				o_rear = rear_q;
			end
			OP_EMPTY: begin
				o_status = STATUS_EMPTY;
				o_count = '0;
			end
			OP_CLR: begin
				o_count = '0;
			end
			OP_DEQ_START: begin
				rd_en = 1'b1;
				rd_addr = ring_next(head_q);
			end
			OP_DEQ_EMIT: begin
				o_data = front_q;
				o_front = (occ_q == '0) ? '0 : rd_q;
				o_rear = (occ_q == '0) ? '0 : rear_q;
			end
			OP_TRAV_START: begin
				rd_en = 1'b1;
				rd_addr = head_q;
			end
			OP_TRAV_EMIT: begin
				rd_en = (rem_q != CW'(1));
				rd_addr = ring_next(idx_q);
				o_data = rd_q;
				o_front = front_q;
				o_rear = rear_q;
				o_last = (rem_q == CW'(1));
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ENQ) begin
			mem[tail_q] <= value;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q <= '0;
			idx_q <= '0;
			rem_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_ENQ: begin
					tail_q <= ring_next(tail_q);
					occ_q <= occ_q + 1'b1;
				end
				OP_CLR: begin
					head_q <= '0;
					tail_q <= '0;
					occ_q <= '0;
				end
				OP_DEQ_START: begin
					head_q <= ring_next(head_q);
					occ_q <= occ_q - 1'b1;
				end
				OP_TRAV_START: begin
					idx_q <= head_q;
					rem_q <= occ_q;
				end
				OP_TRAV_EMIT: begin
					idx_q <= ring_next(idx_q);
					rem_q <= rem_q - 1'b1;
				end
				default: begin
					rem_q <= rem_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ENQ) begin
			rear_q <= value;
			if (occ_q == '0) begin
				front_q <= value;
			end
		end
		if (cmd.op == OP_DEQ_EMIT) begin
			front_q <= rd_q;
		end
		if (cmd.load_out) begin
			status_q <= o_status;
			data_q <= o_data;
			count_q <= COUNT_W'(o_count);
			front_out_q <= o_front;
			rear_out_q <= o_rear;
			last_q <= o_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign data = data_q;
	assign count = count_q;
	assign front_item = front_out_q;
	assign rear_item = rear_out_q;
	assign last = last_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy exceeds depth");

	a_ring_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0 || occ_q == CW'(DEPTH)) |-> head_q == tail_q)
		else $error("head and tail disagree with occupancy");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("result register overwritten while stalled");

	a_trav_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_TRAV_EMIT |-> (rem_q != '0 && rem_q <= occ_q))
		else $error("traverse emits beyond stored items");

endmodule

/* rtl/core/fifo_queue_with_traverse_core.sv */
// Top level of the FIFO queue with traverse.
// Joins the controller fqt_ctrl and the datapath fqt_datapath; uses fqt_pkg.
//
//   channel  direction  handshake            fields
//   input    in         in_valid, in_stall   kind, value
//   output   out        out_valid, out_stall status, data, count, front_item,
//                                            rear_item, last
//
// Enqueue, clear and requests refused as full or empty load their result
// when taken. Dequeue passes through ST_DEQ: the new front word comes from
// the slot memory's registered read port. Traverse passes through ST_TRAV
// and emits one result per stored word, paced by the same read port.
// Reset clears pointers, occupancy and control at once; slot contents stay
// undefined until written, with no clearing pass.
// A stalled result holds in the output register and halts the controller.
module fifo_queue_with_traverse_core import fqt_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                kind,
	input  logic signed [DATA_W-1:0]  value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic signed [DATA_W-1:0]  data,
	output logic [COUNT_W-1:0]        count,
	output logic signed [DATA_W-1:0]  front_item,
	output logic signed [DATA_W-1:0]  rear_item,
	output logic                      last
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	fqt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.stat     (stat),
		.cmd      (cmd)
	);

	fqt_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.data       (data),
		.count      (count),
		.front_item (front_item),
		.rear_item  (rear_item),
		.last       (last)
	);

endmodule
